// File: design/esc_pkg.sv
// Types, constants and microcode for the epoch-seconds to calendar converter.
package esc_pkg;

   localparam int EpochWidth = 32;
   localparam int PcWidth    = 4;

   typedef enum logic [2:0] {
      OP_QUOT  = 3'd0,
      OP_REM   = 3'd1,
      OP_ADD4  = 3'd2,
      OP_YEAR  = 3'd3,
      OP_MONTH = 3'd4,
      OP_DONE  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      DST_NONE = 3'd0,
      DST_SEC  = 3'd1,
      DST_MIN  = 3'd2,
      DST_HR   = 3'd3,
      DST_WD   = 3'd4
   } dst_type;

   typedef struct packed {
      op_type                op;
      dst_type               dst;
      logic [5:0]            divisor;
      logic [PcWidth-1:0]    jmp;
   } uword_type;

   localparam logic [7:0] YearBase  = 8'd70;
   localparam logic [8:0] YearLen   = 9'd365;
   localparam logic [8:0] LeapLen   = 9'd366;
   localparam logic [5:0] SecPerMin = 6'd60;
   localparam logic [5:0] HrPerDay  = 6'd24;
   localparam logic [5:0] DayPerWk  = 6'd7;
   localparam logic [3:0] MonthDec  = 4'd11;

   // quotient = (x * recip) >> shift, exact over the full 32-bit range for 60 and 24; exact for 7 on 16-bit day counts
   localparam logic [31:0] Recip60 = 32'h8888_8889;
   localparam logic [5:0]  Shift60 = 6'd37;
   localparam logic [31:0] Recip24 = 32'hAAAA_AAAB;
   localparam logic [5:0]  Shift24 = 6'd36;
   localparam logic [31:0] Recip7  = 32'h9249_2493;
   localparam logic [5:0]  Shift7  = 6'd34;

   // step program: quotient then remainder for seconds, minutes, hours, weekday,
   // then year and month walks
   function automatic uword_type ucode(input logic [PcWidth-1:0] pc);
      uword_type w;
      case (pc)
         4'd0:    w = '{op: OP_QUOT,  dst: DST_NONE, divisor: SecPerMin, jmp: 4'd1};
         4'd1:    w = '{op: OP_REM,   dst: DST_SEC,  divisor: SecPerMin, jmp: 4'd2};
         4'd2:    w = '{op: OP_QUOT,  dst: DST_NONE, divisor: SecPerMin, jmp: 4'd3};
         4'd3:    w = '{op: OP_REM,   dst: DST_MIN,  divisor: SecPerMin, jmp: 4'd4};
         4'd4:    w = '{op: OP_QUOT,  dst: DST_NONE, divisor: HrPerDay,  jmp: 4'd5};
         4'd5:    w = '{op: OP_REM,   dst: DST_HR,   divisor: HrPerDay,  jmp: 4'd6};
         4'd6:    w = '{op: OP_ADD4,  dst: DST_NONE, divisor: 6'd1,      jmp: 4'd7};
         4'd7:    w = '{op: OP_QUOT,  dst: DST_NONE, divisor: DayPerWk,  jmp: 4'd8};
         4'd8:    w = '{op: OP_REM,   dst: DST_WD,   divisor: DayPerWk,  jmp: 4'd9};
         4'd9:    w = '{op: OP_YEAR,  dst: DST_NONE, divisor: 6'd1,      jmp: 4'd10};
         4'd10:   w = '{op: OP_MONTH, dst: DST_NONE, divisor: 6'd1,      jmp: 4'd11};
         4'd11:   w = '{op: OP_DONE,  dst: DST_NONE, divisor: 6'd1,      jmp: 4'd0};
         default: w = '{op: OP_DONE,  dst: DST_NONE, divisor: 6'd1,      jmp: 4'd0};
      endcase
      return w;
   endfunction

   function automatic logic [31:0] recip_of(input logic [5:0] divisor);
      logic [31:0] r;
      case (divisor)
         SecPerMin: r = Recip60;
         HrPerDay:  r = Recip24;
         DayPerWk:  r = Recip7;
         default:   r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] shift_of(input logic [5:0] divisor);
      logic [5:0] s;
      case (divisor)
         SecPerMin: s = Shift60;
         HrPerDay:  s = Shift24;
         DayPerWk:  s = Shift7;
         default:   s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
      logic [4:0] ml;
      case (mon)
         4'd0:    ml = 5'd31;
         4'd1:    ml = leap ? 5'd29 : 5'd28;
         4'd2:    ml = 5'd31;
         4'd3:    ml = 5'd30;
         4'd4:    ml = 5'd31;
         4'd5:    ml = 5'd30;
         4'd6:    ml = 5'd31;
         4'd7:    ml = 5'd31;
         4'd8:    ml = 5'd30;
         4'd9:    ml = 5'd31;
         4'd10:   ml = 5'd30;
         4'd11:   ml = 5'd31;
         default: ml = 5'd31;
      endcase
      return ml;
   endfunction

endpackage

// File: design/epoch_seconds_to_calendar.sv
// Epoch seconds to calendar time: microcoded sequencer over a reciprocal-multiply datapath.
// The result is loaded after the seconds, minutes, hours and weekday steps and the year and month walks;
// the year walk takes off one year and the month walk one month per step, up to month index 11.
// One item at a time: req_stall is high while busy; a stalled result holds the sequencer.
// Synchronous active-high reset clears the sequencer and output valid; no clearing pass.
module epoch_seconds_to_calendar (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [esc_pkg::EpochWidth-1:0] req_epoch_seconds,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [5:0]                     rsp_second_of_minute,
   output logic [5:0]                     rsp_minute_of_hour,
   output logic [4:0]                     rsp_hour_of_day,
   output logic [2:0]                     rsp_weekday,
   output logic [7:0]                     rsp_years_since_1900,
   output logic [8:0]                     rsp_day_of_year,
   output logic [3:0]                     rsp_month_index,
   output logic [4:0]                     rsp_day_of_month
);
   import esc_pkg::*;

   logic                  busy_ff, busy_in;
   logic [PcWidth-1:0]    pc_ff, pc_in;
   logic [EpochWidth-1:0] acc_ff, acc_in;
   logic [EpochWidth-1:0] quot_ff, quot_in;
   logic [15:0]           days_ff, days_in;
   logic [7:0]            yr_ff, yr_in;
   logic [3:0]            mon_ff, mon_in;
   logic [5:0]            sec_ff, sec_in;
   logic [5:0]            min_ff, min_in;
   logic [4:0]            hr_ff, hr_in;
   logic [2:0]            wd_ff, wd_in;
   logic [8:0]            doy_ff, doy_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [5:0]            rsp_sec_ff;
   logic [5:0]            rsp_min_ff;
   logic [4:0]            rsp_hr_ff;
   logic [2:0]            rsp_wd_ff;
   logic [7:0]            rsp_yr_ff;
   logic [8:0]            rsp_doy_ff;
   logic [3:0]            rsp_mon_ff;
   logic [4:0]            rsp_dom_ff;
   logic                  rsp_load;

   uword_type             uw;
   logic [31:0]           recip;
   logic [5:0]            rshift;
   logic [63:0]           prod;
   logic [31:0]           quot_new;
   logic [31:0]           back;
   logic [31:0]           rem_full;
   logic [5:0]            rem_new;
   logic                  leap;
   logic [8:0]            ylen;
   logic [4:0]            ml;
   logic                  out_free;
   logic                  accept;

   assign uw       = ucode(pc_ff);
   assign recip    = recip_of(uw.divisor);
   assign rshift   = shift_of(uw.divisor);
   assign prod     = {32'b0, acc_ff} * {32'b0, recip};
   assign quot_new = 32'(prod >> rshift);
   assign back     = quot_ff * {26'b0, uw.divisor};
   assign rem_full = acc_ff - back;
   assign rem_new  = rem_full[5:0];
   assign leap     = (yr_ff[1:0] == 2'b00);
   assign ylen     = leap ? LeapLen : YearLen;
   assign ml       = month_len(mon_ff, leap);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy_ff;
   assign accept   = req_valid && !busy_ff;

   always_comb begin
      busy_in  = busy_ff;
      pc_in    = pc_ff;
      acc_in   = acc_ff;
      quot_in  = quot_ff;
      days_in  = days_ff;
      yr_in    = yr_ff;
      mon_in   = mon_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hr_in    = hr_ff;
      wd_in    = wd_ff;
      doy_in   = doy_ff;
      rsp_load = 1'b0;
      if (!busy_ff) begin
         if (accept) begin
            busy_in = 1'b1;
            pc_in   = '0;
            acc_in  = req_epoch_seconds;
            yr_in   = YearBase;
            mon_in  = '0;
         end
      end else begin
         case (uw.op)
            OP_QUOT: begin
               quot_in = quot_new;
               pc_in   = uw.jmp;
            end
            OP_REM: begin
               acc_in = quot_ff;
               pc_in  = uw.jmp;
               case (uw.dst)
                  DST_SEC: sec_in = rem_new;
                  DST_MIN: min_in = rem_new;
                  DST_HR:  hr_in  = rem_new[4:0];
                  DST_WD:  wd_in  = rem_new[2:0];
                  default: ;
               endcase
            end
            OP_ADD4: begin
               days_in = acc_ff[15:0];
               acc_in  = {16'b0, acc_ff[15:0] + 16'd4};
               pc_in   = uw.jmp;
            end
            OP_YEAR: begin
               if (days_ff >= {7'b0, ylen}) begin
                  days_in = days_ff - {7'b0, ylen};
                  yr_in   = yr_ff + 1'b1;
               end else begin
                  doy_in = days_ff[8:0];
                  pc_in  = uw.jmp;
               end
            end
            OP_MONTH: begin
               if (days_ff[8:0] >= {4'b0, ml} && mon_ff != MonthDec) begin
                  days_in = days_ff - {11'b0, ml};
                  mon_in  = mon_ff + 1'b1;
               end else begin
                  pc_in = uw.jmp;
               end
            end
            OP_DONE: begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  busy_in  = 1'b0;
                  pc_in    = uw.jmp;
               end
            end
            default: begin
               busy_in = 1'b0;
               pc_in   = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      quot_ff <= quot_in;
      days_ff <= days_in;
      yr_ff   <= yr_in;
      mon_ff  <= mon_in;
      sec_ff  <= sec_in;
      min_ff  <= min_in;
      hr_ff   <= hr_in;
      wd_ff   <= wd_in;
      doy_ff  <= doy_in;
      if (rsp_load) begin
         rsp_sec_ff <= sec_ff;
         rsp_min_ff <= min_ff;
         rsp_hr_ff  <= hr_ff;
         rsp_wd_ff  <= wd_ff;
         rsp_yr_ff  <= yr_ff;
         rsp_doy_ff <= doy_ff;
         rsp_mon_ff <= mon_ff;
         rsp_dom_ff <= days_ff[4:0] + 5'd1;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_second_of_minute = rsp_sec_ff;
   assign rsp_minute_of_hour   = rsp_min_ff;
   assign rsp_hour_of_day      = rsp_hr_ff;
   assign rsp_weekday          = rsp_wd_ff;
   assign rsp_years_since_1900 = rsp_yr_ff;
   assign rsp_day_of_year      = rsp_doy_ff;
   assign rsp_month_index      = rsp_mon_ff;
   assign rsp_day_of_month     = rsp_dom_ff;

endmodule

// File: tb/sv/epoch_seconds_to_calendar_tb.sv
// Testbench for epoch_seconds_to_calendar: directed and random epochs against a predictor.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;

   typedef struct packed {
      logic [5:0] sec;
      logic [5:0] min;
      logic [4:0] hour;
      logic [2:0] wday;
      logic [7:0] year;
      logic [8:0] yday;
      logic [3:0] mon;
      logic [4:0] mday;
   } calendar_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [esc_pkg::EpochWidth-1:0] req_epoch_seconds = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [5:0]                     rsp_second_of_minute;
   logic [5:0]                     rsp_minute_of_hour;
   logic [4:0]                     rsp_hour_of_day;
   logic [2:0]                     rsp_weekday;
   logic [7:0]                     rsp_years_since_1900;
   logic [8:0]                     rsp_day_of_year;
   logic [3:0]                     rsp_month_index;
   logic [4:0]                     rsp_day_of_month;

   logic         idle_on = 1'b1;
   calendar_type pending_dates[$];
   int           date_errors = 0;

   epoch_seconds_to_calendar dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_weekday          (rsp_weekday),
      .rsp_years_since_1900 (rsp_years_since_1900),
      .rsp_day_of_year      (rsp_day_of_year),
      .rsp_month_index      (rsp_month_index),
      .rsp_day_of_month     (rsp_day_of_month)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[epoch_seconds_to_calendar] ERROR");
      $finish;
   end

   // simplified leap rule: every fourth year, 2100 included
   function automatic calendar_type calendar_of(input logic [31:0] secs);
      calendar_type c;
      int unsigned  t;
      int unsigned  days;
      int unsigned  yr;
      int unsigned  m;
      int unsigned  mlen;
      int unsigned  month_days[12];
      month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      t      = secs;
      c.sec  = 6'(t % 60);
      t      = t / 60;
      c.min  = 6'(t % 60);
      t      = t / 60;
      c.hour = 5'(t % 24);
      days   = t / 24;
      c.wday = 3'((days + 4) % 7);
      yr = 1970;
      while (days >= ((yr % 4 == 0) ? 366 : 365)) begin
         days -= (yr % 4 == 0) ? 366 : 365;
         yr++;
      end
      c.year = 8'(yr - 1900);
      c.yday = 9'(days);
      m = 0;
      while (m < 11) begin
         mlen = (m == 1 && yr % 4 == 0) ? 29 : month_days[m];
         if (days < mlen) break;
         days -= mlen;
         m++;
      end
      c.mon  = 4'(m);
      c.mday = 5'(days + 1);
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      date_errors++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= idle_on && ($urandom_range(99) < 29);
   end

   always @(posedge clock) begin
      calendar_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_dates.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = pending_dates.pop_front();
            check_field("second_of_minute", 32'(rsp_second_of_minute), 32'(want.sec));
            check_field("minute_of_hour", 32'(rsp_minute_of_hour), 32'(want.min));
            check_field("hour_of_day", 32'(rsp_hour_of_day), 32'(want.hour));
            check_field("weekday", 32'(rsp_weekday), 32'(want.wday));
            check_field("years_since_1900", 32'(rsp_years_since_1900), 32'(want.year));
            check_field("day_of_year", 32'(rsp_day_of_year), 32'(want.yday));
            check_field("month_index", 32'(rsp_month_index), 32'(want.mon));
            check_field("day_of_month", 32'(rsp_day_of_month), 32'(want.mday));
         end
      end
   end

   task automatic send_epoch(input logic [31:0] secs);
      int gap;
      if (idle_on && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (req_stall);
      pending_dates.push_back(calendar_of(secs));
   endtask

   task automatic test_field_extremes;
      send_epoch(32'd0);
      send_epoch(32'hFFFF_FFFF);
      send_epoch(32'd1);
      send_epoch(32'd59);
      send_epoch(32'd60);
      send_epoch(32'd3599);
      send_epoch(32'd3600);
      send_epoch(32'd86399);
      send_epoch(32'd86400);
      send_epoch(32'h7FFF_FFFF);
      send_epoch(32'h8000_0000);
      send_epoch(32'hAAAA_AAAA);
      send_epoch(32'h5555_5555);
   endtask

   task automatic test_leap_rule;
      send_epoch(32'd31449600);    // 1970-12-31
      send_epoch(32'd68169600);    // 1972-02-29
      send_epoch(32'd68255999);
      send_epoch(32'd94608000);    // 1972-12-31, day 365
      send_epoch(32'd4107542400);  // 2100-02-29
      send_epoch(32'd4133980800);  // 2100-12-31
      send_epoch(32'd4291833600);  // 2106-01-01
      send_epoch(32'd4291833599);
   endtask

   task automatic test_random_span(input int count);
      int unsigned pick;
      int unsigned day;
      logic [31:0] secs;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(9);
         if (pick < 5) begin
            secs = $urandom;
         end else if (pick < 7) begin
            secs = $urandom_range(34_560_000);
         end else begin
            day  = $urandom_range(49710);
            secs = 32'(day * 86400 + ($urandom_range(1) ? 0 : 86399));
         end
         send_epoch(secs);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes;
      test_leap_rule;
      idle_on <= 1'b0;
      test_random_span(120);
      idle_on <= 1'b1;
      test_random_span(360);
      req_valid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (date_errors == 0) $display("[epoch_seconds_to_calendar] OK");
      else $display("[epoch_seconds_to_calendar] ERROR");
      $finish;
   end

endmodule
